// File: design/sha1_pkg.sv
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared constants, types and helpers for the SHA-1 message hasher.
// ----------------------------------------------------------------------------
package sha1_pkg;

    localparam int unsigned WordW   = 32;
    localparam int unsigned HashN   = 5;
    localparam int unsigned BlockN  = 16;
    localparam int unsigned Rounds  = 80;
    localparam int unsigned NbW     = 3;
    localparam int unsigned IdxW    = 3;
    localparam int unsigned SlotW   = 4;
    localparam int unsigned RndW    = 7;
    localparam int unsigned LenW    = 64;

    typedef logic [WordW-1:0] t_word;

    localparam t_word IV [HashN] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam t_word K0 = 32'h5A827999;
    localparam t_word K1 = 32'h6ED9EBA1;
    localparam t_word K2 = 32'h8F1BBCDC;
    localparam t_word K3 = 32'hCA62C1D6;

    localparam t_word PAD_MARK = 32'h80000000;
    localparam logic [7:0] MARK_BYTE = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } t_state;

    function automatic t_word rotl(input t_word x, input int unsigned n);
        t_word r;
        r = (x << n) | (x >> (WordW - n));
        return r;
    endfunction

endpackage

// File: design/sha1_message_hasher.sv
// ----------------------------------------------------------------------------
// sha1_message_hasher
// SHA-1 over a byte message delivered as big-endian 32-bit words.
// ----------------------------------------------------------------------------
// Message words enter on the slave stream, one word per handshake, first byte
// in bits 31..24; tuser carries the valid byte count (only meaningful on the
// final word, values above four count as four) and tlast marks the final word.
// Words fill a 16-deep shift line that doubles as the message schedule. Each
// full block is compressed by one round unit, one round per cycle, and the
// working variables are then folded into the chaining value; the input is not
// ready meanwhile. A non-final word that does not close a block is taken
// without leaving the idle state. After the final word the sequencer writes
// the 0x80 marker, zero fill and the 64-bit bit length one word per cycle,
// pausing while a block is compressed and compressing a second block when
// needed, then presents the five digest words on the master stream (tuser =
// index 0..4, tlast on index 4) and re-arms for the next message.
// ----------------------------------------------------------------------------
module sha1_message_hasher (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [sha1_pkg::WordW-1:0]    s_axis_tdata,   // [31:0] data_word
    input  logic [sha1_pkg::NbW-1:0]      s_axis_tuser,   // [2:0] bytes_valid
    input  logic                          s_axis_tlast,   // final_word
    // master stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [sha1_pkg::WordW-1:0]    m_axis_tdata,   // [31:0] digest_word
    output logic [sha1_pkg::IdxW-1:0]     m_axis_tuser,   // [2:0] digest_index
    output logic                          m_axis_tlast    // digest_last
);
    import sha1_pkg::*;

    t_state             r_state, n_state;
    t_word              r_h [HashN];
    t_word              n_h [HashN];
    t_word              r_v [HashN];          // working vars a..e
    t_word              n_v [HashN];
    t_word              r_w [BlockN];         // block buffer / schedule line
    logic [LenW-1:0]    r_len, n_len;
    logic [SlotW-1:0]   r_slot, n_slot;
    logic [RndW-1:0]    r_rnd, n_rnd;
    logic               r_fin, n_fin;         // padding in progress
    logic               r_mark, n_mark;       // marker word still owed
    logic               r_hi_done, n_hi_done; // length high word written
    logic [IdxW-1:0]    r_idx, n_idx;

    // shift line control
    logic               shift_en;
    t_word              shift_word;
    logic               put_en;

    // round unit
    t_word              f_val;
    t_word              k_val;
    t_word              round_sum;
    t_word              sched_word;
    logic [NbW-1:0]     nb_c;

    always_comb begin
        if (r_rnd < 7'd20) begin
            f_val = (r_v[1] & r_v[2]) | (~r_v[1] & r_v[3]);
            k_val = K0;
        end else if (r_rnd < 7'd40) begin
            f_val = r_v[1] ^ r_v[2] ^ r_v[3];
            k_val = K1;
        end else if (r_rnd < 7'd60) begin
            f_val = (r_v[1] & r_v[2]) | (r_v[1] & r_v[3]) | (r_v[2] & r_v[3]);
            k_val = K2;
        end else begin
            f_val = r_v[1] ^ r_v[2] ^ r_v[3];
            k_val = K3;
        end
        round_sum  = rotl(r_v[0], 5) + f_val + r_v[4] + k_val + r_w[0];
        sched_word = rotl(r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0], 1);
    end

    assign nb_c = (s_axis_tuser > NbW'(4)) ? NbW'(4) : s_axis_tuser;

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_h       = r_h;
        n_v       = r_v;
        n_len     = r_len;
        n_slot    = r_slot;
        n_rnd     = r_rnd;
        n_fin     = r_fin;
        n_mark    = r_mark;
        n_hi_done = r_hi_done;
        n_idx     = r_idx;
        shift_en  = 1'b0;
        put_en    = 1'b0;
        shift_word = '0;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    put_en = 1'b1;
                    if (!s_axis_tlast) begin
                        shift_word = s_axis_tdata;
                        n_len      = r_len + LenW'(32);
                    end else begin
                        n_fin = 1'b1;
                        n_len = r_len + {{(LenW-NbW-3){1'b0}}, nb_c, 3'b000};
                        case (nb_c)
                            3'd0: shift_word = PAD_MARK;
                            3'd1: shift_word = {s_axis_tdata[31:24], MARK_BYTE, 16'h0};
                            3'd2: shift_word = {s_axis_tdata[31:16], MARK_BYTE, 8'h0};
                            3'd3: shift_word = {s_axis_tdata[31:8], MARK_BYTE};
                            default: begin
                                shift_word = s_axis_tdata;
                                n_mark     = 1'b1;
                            end
                        endcase
                    end
                end
            end
            ST_PAD: begin
                put_en = 1'b1;
                if (r_mark) begin
                    shift_word = PAD_MARK;
                    n_mark     = 1'b0;
                end else if (r_slot == SlotW'(14)) begin
                    shift_word = r_len[63:32];
                    n_hi_done  = 1'b1;
                end else if (r_slot == SlotW'(15) && r_hi_done) begin
                    shift_word = r_len[31:0];
                end else begin
                    shift_word = '0;
                end
            end
            ST_ROUND: begin
                shift_en   = 1'b1;
                shift_word = sched_word;
                n_v[0] = round_sum;
                n_v[1] = r_v[0];
                n_v[2] = rotl(r_v[1], 30);
                n_v[3] = r_v[2];
                n_v[4] = r_v[3];
                n_rnd  = r_rnd + 7'd1;
                if (r_rnd == RndW'(Rounds - 1)) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                for (int i = 0; i < HashN; i++) begin
                    n_h[i] = r_h[i] + r_v[i];
                end
                n_idx = '0;
                if (!r_fin) begin
                    n_state = ST_IDLE;
                end else if (r_hi_done) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_PAD;
                end
            end
            ST_OUT: begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready) begin
                    n_idx = r_idx + IdxW'(1);
                    if (r_idx == IdxW'(HashN - 1)) begin
                        n_h       = IV;
                        n_len     = '0;
                        n_slot    = '0;
                        n_fin     = 1'b0;
                        n_mark    = 1'b0;
                        n_hi_done = 1'b0;
                        n_idx     = '0;
                        n_state   = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // a word written into the block buffer; the 16th starts a compression
        if (put_en) begin
            shift_en = 1'b1;
            n_slot   = r_slot + SlotW'(1);
            if (r_slot == SlotW'(BlockN - 1)) begin
                n_state = ST_ROUND;
                n_rnd   = '0;
                n_v     = r_h;
            end else begin
                n_state = n_fin ? ST_PAD : ST_IDLE;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_h       <= IV;
            r_len     <= '0;
            r_slot    <= '0;
            r_rnd     <= '0;
            r_fin     <= 1'b0;
            r_mark    <= 1'b0;
            r_hi_done <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_state   <= n_state;
            r_h       <= n_h;
            r_len     <= n_len;
            r_slot    <= n_slot;
            r_rnd     <= n_rnd;
            r_fin     <= n_fin;
            r_mark    <= n_mark;
            r_hi_done <= n_hi_done;
            r_idx     <= n_idx;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '{default: '0};
        end else begin
            r_v <= n_v;
        end
        if (shift_en) begin
            for (int i = 0; i < BlockN - 1; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[BlockN-1] <= shift_word;
        end
    end

    assign m_axis_tdata = r_h[r_idx];
    assign m_axis_tuser = r_idx;
    assign m_axis_tlast = (r_idx == IdxW'(HashN - 1));

endmodule
